### rtl/polynomial_delay_predictor_assert.svh
// Assertion macros shared by the predictor modules.
// Expects clk and arst_n in the scope of use.
`ifndef POLYNOMIAL_DELAY_PREDICTOR_ASSERT_SVH
`define POLYNOMIAL_DELAY_PREDICTOR_ASSERT_SVH

// Plain clocked check, off during reset.
`define PDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define PDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pdp_pkg.sv
// Shared types, sizes and the monomial exponent table of the predictor.
// No dependencies.
`timescale 1ns / 1ps
package pdp_pkg;

	localparam int EMBED_DIM = 2;
	localparam int ORDER     = 2;
	localparam int MAX_DELAY = 8;

	localparam int BASE       = ORDER + 1;
	localparam int CODE_SPACE = BASE ** EMBED_DIM;
	localparam int WIN_LEN    = (EMBED_DIM - 1) * MAX_DELAY + 1;

	localparam int SMP_W   = 16;
	localparam int COEF_W  = 24;
	localparam int IDX_W   = 4;
	localparam int CFG_W   = 4;
	localparam int SQ_W    = 32;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 24;
	localparam int DIFF_W  = SMP_W + 1;
	localparam int FRAC    = 12;
	// monomial magnitude stays at or below 2^(12+3*ORDER)
	localparam int M_W     = FRAC + 3 * ORDER + 2;
	localparam int A_W     = (COEF_W > M_W) ? ((COEF_W > DIFF_W) ? COEF_W : DIFF_W)
	                                         : ((M_W > DIFF_W) ? M_W : DIFF_W);
	localparam int B_W     = (M_W > DIFF_W) ? M_W : DIFF_W;
	localparam int PROD_W  = A_W + B_W;
	localparam int ACC_W   = PROD_W + 7;
	localparam int EXP_W   = $clog2(ORDER + 1);
	localparam int K_W     = $clog2(EMBED_DIM + 1);
	localparam int TAP_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
	localparam int FILL_W  = $clog2(WIN_LEN + 1);
	localparam int DLY_W   = $clog2(MAX_DELAY + 1);

	function automatic int digit_sum(input int code);
		int rem;
		int s;
		rem = code;
		s = 0;
		for (int k = 0; k < EMBED_DIM; k++) begin
			s = s + rem % BASE;
			rem = rem / BASE;
		end
		return s;
	endfunction

	function automatic int count_terms();
		int n;
		n = 0;
		for (int t = 0; t < CODE_SPACE; t++) begin
			if (digit_sum(t) <= ORDER) n = n + 1;
		end
		return n;
	endfunction

	localparam int TERM_CNT = count_terms();
	localparam int P_W      = (TERM_CNT > 1) ? $clog2(TERM_CNT) : 1;
	localparam int TBL_W    = TERM_CNT * EMBED_DIM * EXP_W;

	// coordinate EMBED_DIM-1 is the least significant digit of the code
	function automatic logic [TBL_W-1:0] build_exp();
		logic [TBL_W-1:0] tbl;
		int n;
		int rem;
		tbl = '0;
		n = 0;
		for (int t = 0; t < CODE_SPACE; t++) begin
			if (digit_sum(t) <= ORDER) begin
				rem = t;
				for (int k = EMBED_DIM - 1; k >= 0; k--) begin
					tbl[(n * EMBED_DIM + k) * EXP_W +: EXP_W] = EXP_W'(rem % BASE);
					rem = rem / BASE;
				end
				n = n + 1;
			end
		end
		return tbl;
	endfunction

	localparam logic [TBL_W-1:0] TERM_EXP = build_exp();

	function automatic logic [EXP_W-1:0] exp_of(input logic [P_W-1:0] p,
		input logic [K_W-1:0] k);
		logic [EXP_W-1:0] e;
		e = '0;
		for (int i = 0; i < TERM_CNT; i++) begin
			for (int j = 0; j < EMBED_DIM; j++) begin
				if (int'(p) == i && int'(k) == j)
					e = TERM_EXP[(i * EMBED_DIM + j) * EXP_W +: EXP_W];
			end
		end
		return e;
	endfunction

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_START,
		CMD_SCORE_MUL,
		CMD_SCORE_ACC,
		CMD_TERM_INIT,
		CMD_FACTOR_MUL,
		CMD_FACTOR_RND,
		CMD_COEF_MUL,
		CMD_COEF_ACC,
		CMD_ROUND,
		CMD_FINISH
	} pdp_op_t;

	typedef struct packed {
		pdp_op_t        op;
		logic [P_W-1:0] p;
		logic [K_W-1:0] k;
	} pdp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic last_valid;
		logic win_full;
		logic out_free;
	} pdp_stat_t;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

endpackage

### rtl/pdp_ctrl.sv
// Sequencer for the predictor: walks scoring, monomials and coefficient terms.
// Depends on pdp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "polynomial_delay_predictor_assert.svh"
module pdp_ctrl import pdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pdp_stat_t stat,
	output pdp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCORE_MUL,
		S_SCORE_ACC,
		S_TERM_INIT,
		S_FACTOR,
		S_FACTOR_RND,
		S_COEF_MUL,
		S_COEF_ACC,
		S_ROUND,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [P_W-1:0]   p_q;
	logic [K_W-1:0]   k_q;
	logic [EXP_W-1:0] e_q;
	logic [EXP_W-1:0] exp_cur;
	logic             k_done;

	assign exp_cur  = exp_of(p_q, k_q);
	assign k_done   = (k_q == K_W'(EMBED_DIM));
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.p  = p_q;
		cmd.k  = k_q;
		cmd.op = CMD_NONE;
		unique case (state_q)
			S_IDLE:       cmd.op = in_valid ? CMD_START : CMD_NONE;
			S_SCORE_MUL:  cmd.op = stat.is_load ? CMD_NONE : CMD_SCORE_MUL;
			S_SCORE_ACC:  cmd.op = CMD_SCORE_ACC;
			S_TERM_INIT:  cmd.op = CMD_TERM_INIT;
			S_FACTOR:     cmd.op = (!k_done && e_q < exp_cur) ? CMD_FACTOR_MUL : CMD_NONE;
			S_FACTOR_RND: cmd.op = CMD_FACTOR_RND;
			S_COEF_MUL:   cmd.op = CMD_COEF_MUL;
			S_COEF_ACC:   cmd.op = CMD_COEF_ACC;
			S_ROUND:      cmd.op = CMD_ROUND;
			S_FINISH:     cmd.op = stat.out_free ? CMD_FINISH : CMD_NONE;
			default:      cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			k_q     <= '0;
			e_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCORE_MUL;
				end
				S_SCORE_MUL: begin
					state_q <= stat.is_load ? S_FINISH : S_SCORE_ACC;
				end
				S_SCORE_ACC: begin
					p_q     <= '0;
					state_q <= stat.win_full ? S_TERM_INIT : S_FINISH;
				end
				S_TERM_INIT: begin
					k_q     <= '0;
					e_q     <= '0;
					state_q <= S_FACTOR;
				end
				S_FACTOR: begin
					if (k_done) begin
						state_q <= S_COEF_MUL;
					end else if (e_q < exp_cur) begin
						e_q     <= e_q + 1'b1;
						state_q <= S_FACTOR_RND;
					end else begin
						k_q <= k_q + 1'b1;
						e_q <= '0;
					end
				end
				S_FACTOR_RND: state_q <= S_FACTOR;
				S_COEF_MUL:   state_q <= S_COEF_ACC;
				S_COEF_ACC: begin
					if (p_q == P_W'(TERM_CNT - 1)) begin
						state_q <= S_ROUND;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_TERM_INIT;
					end
				end
				S_ROUND:      state_q <= S_FINISH;
				S_FINISH: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default:      state_q <= S_IDLE;
			endcase
		end
	end

	`PDP_ASSERT_NEXT(a_start_busy, cmd.op == CMD_START, state_q == S_SCORE_MUL,
		"request accepted but sequencer did not leave idle")
	`PDP_ASSERT(a_term_range, p_q < P_W'(TERM_CNT), "term counter out of range")

endmodule

### rtl/pdp_dpath.sv
// Datapath: delay line, coefficient store, shared multiplier, sums and result register.
// Depends on pdp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "polynomial_delay_predictor_assert.svh"
module pdp_dpath import pdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pdp_cmd_t                 cmd,
	output pdp_stat_t                stat,
	input  logic [DLY_W-1:0]         delay,
	input  logic                     opcode,
	input  logic                     restart,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic [IDX_W-1:0]         coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SMP_W-1:0]  prediction,
	output logic                     pred_valid,
	output logic [SQ_W-1:0]          sq_error,
	output logic                     err_valid,
	output logic [SUM_W-1:0]         error_sum,
	output logic [CNT_W-1:0]         scored_count,
	output logic                     saturated
);

	logic signed [SMP_W-1:0]  win_q [WIN_LEN];
	logic signed [COEF_W-1:0] coef_q [TERM_CNT];
	logic [FILL_W-1:0]        fill_q;
	logic signed [SMP_W-1:0]  last_pred_q;
	logic                     last_valid_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         count_q;
	logic                     opld_q;
	logic signed [SMP_W-1:0]  sample_q;
	logic signed [M_W-1:0]    m_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SMP_W-1:0]  pred_q;
	logic                     pvalid_q;
	logic [SQ_W-1:0]          sq_q;
	logic                     evalid_q;
	logic                     sat_q;

	logic [FILL_W-1:0]        fill_base;
	logic [FILL_W-1:0]        need;
	logic [TAP_W-1:0]         tap_idx;
	logic signed [DIFF_W-1:0] diff;
	logic signed [A_W-1:0]    mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd_m;
	logic [SUM_W:0]           sum_next;
	logic signed [ACC_W-1:0]  rnd_acc;
	logic                     clip_hi;
	logic                     clip_lo;

	assign fill_base = restart ? '0 : fill_q;
	assign need      = FILL_W'((EMBED_DIM - 1) * int'(delay) + 1);
	assign tap_idx   = TAP_W'(int'(cmd.k) * int'(delay));
	assign diff      = DIFF_W'(sample_q) - DIFF_W'(last_pred_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			CMD_SCORE_MUL: begin
				mul_a = A_W'(diff);
				mul_b = B_W'(diff);
			end
			CMD_FACTOR_MUL: begin
				mul_a = A_W'(m_q);
				mul_b = B_W'(win_q[tap_idx]);
			end
			CMD_COEF_MUL: begin
				mul_a = A_W'(coef_q[cmd.p]);
				mul_b = B_W'(m_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign rnd_m    = (prod_q + PROD_W'(1 << (FRAC - 1))) >>> FRAC;
	assign sum_next = {1'b0, sum_q} + (SUM_W + 1)'(prod_q[SQ_W-1:0]);
	assign rnd_acc  = (acc_q + ACC_W'(1 << 15)) >>> 16;
	assign clip_hi  = rnd_acc > ACC_W'(32767);
	assign clip_lo  = rnd_acc < -ACC_W'(32768);

	assign stat.is_load    = opld_q;
	assign stat.last_valid = last_valid_q;
	assign stat.win_full   = (fill_q >= need);
	assign stat.out_free   = !out_valid || !out_stall;

	// payload of the item in flight
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_START: begin
				opld_q   <= opcode;
				sample_q <= sample;
				acc_q    <= '0;
				pred_q   <= '0;
				sq_q     <= '0;
				if (opcode == OP_SAMPLE) begin
					win_q[0] <= sample;
					for (int i = 1; i < WIN_LEN; i++) win_q[i] <= win_q[i-1];
				end
			end
			CMD_SCORE_MUL, CMD_FACTOR_MUL, CMD_COEF_MUL: prod_q <= prod;
			CMD_SCORE_ACC: begin
				if (last_valid_q) sq_q <= prod_q[SQ_W-1:0];
			end
			CMD_TERM_INIT:  m_q   <= M_W'(1 << FRAC);
			CMD_FACTOR_RND: m_q   <= M_W'(rnd_m);
			CMD_COEF_ACC:   acc_q <= acc_q + ACC_W'(prod_q);
			CMD_ROUND: begin
				if (clip_hi)      pred_q <= SMP_W'(32767);
				else if (clip_lo) pred_q <= -SMP_W'(32768);
				else              pred_q <= SMP_W'(rnd_acc);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERM_CNT; i++) coef_q[i] <= '0;
			fill_q       <= '0;
			last_pred_q  <= '0;
			last_valid_q <= 1'b0;
			sum_q        <= '0;
			count_q      <= '0;
			pvalid_q     <= 1'b0;
			evalid_q     <= 1'b0;
			sat_q        <= 1'b0;
			out_valid    <= 1'b0;
			prediction   <= '0;
			pred_valid   <= 1'b0;
			sq_error     <= '0;
			err_valid    <= 1'b0;
			error_sum    <= '0;
			scored_count <= '0;
			saturated    <= 1'b0;
		end else begin
			if (out_valid && !out_stall && cmd.op != CMD_FINISH) out_valid <= 1'b0;
			unique case (cmd.op)
				CMD_START: begin
					pvalid_q <= 1'b0;
					evalid_q <= 1'b0;
					sat_q    <= 1'b0;
					if (restart) begin
						last_valid_q <= 1'b0;
						last_pred_q  <= '0;
						sum_q        <= '0;
						count_q      <= '0;
					end
					if (opcode == OP_LOAD) begin
						fill_q <= fill_base;
						if ({1'b0, coef_index} < (IDX_W + 1)'(TERM_CNT))
							coef_q[P_W'(coef_index)] <= coef_value;
					end else begin
						fill_q <= (fill_base < FILL_W'(WIN_LEN)) ? fill_base + 1'b1
						                                           : fill_base;
					end
				end
				CMD_SCORE_ACC: begin
					if (last_valid_q) begin
						evalid_q <= 1'b1;
						if (sum_next[SUM_W]) begin
							sum_q <= '1;
							sat_q <= 1'b1;
						end else begin
							sum_q <= sum_next[SUM_W-1:0];
						end
						if (count_q != '1) count_q <= count_q + 1'b1;
					end
				end
				CMD_ROUND: begin
					pvalid_q <= 1'b1;
					if (clip_hi || clip_lo) sat_q <= 1'b1;
				end
				CMD_FINISH: begin
					out_valid    <= 1'b1;
					prediction   <= pred_q;
					pred_valid   <= pvalid_q;
					sq_error     <= sq_q;
					err_valid    <= evalid_q;
					error_sum    <= sum_q;
					scored_count <= count_q;
					saturated    <= sat_q;
					if (!opld_q) begin
						last_pred_q  <= pred_q;
						last_valid_q <= pvalid_q;
					end
				end
				default: ;
			endcase
		end
	end

	`PDP_ASSERT(a_pred_needs_full, !(cmd.op == CMD_ROUND && !stat.win_full),
		"prediction formed with window not full")
	`PDP_ASSERT_NEXT(a_count_mono, cmd.op != CMD_START, count_q >= $past(count_q),
		"score count dropped without restart")

endmodule

### rtl/polynomial_delay_predictor.sv
// Top level of the polynomial delay predictor: APB register, sequencer, datapath.
// Depends on pdp_pkg, pdp_ctrl and pdp_dpath.
//
//   channel   signals                                    direction
//   input     in_valid/in_stall + opcode..coef_value     request in
//   output    out_valid/out_stall + prediction..saturated result out
//   config    APB psel/penable/pwrite/paddr/pwdata       register embed_delay
//
// A coefficient load runs start, score and finish; a sample whose window is not yet
// full also accumulates its score; a full-window sample then walks every term (init,
// factor products, coefficient multiply and accumulate), then rounds; one shared multiplier.
// Reset clears the sums, fill, last prediction and coefficients at once.
// A held result does not block the next request; only a second finished result waits.
`timescale 1ns / 1ps
module polynomial_delay_predictor import pdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic                     restart,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic [IDX_W-1:0]         coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SMP_W-1:0]  prediction,
	output logic                     pred_valid,
	output logic [SQ_W-1:0]          sq_error,
	output logic                     err_valid,
	output logic [SUM_W-1:0]         error_sum,
	output logic [CNT_W-1:0]         scored_count,
	output logic                     saturated
);

	logic [CFG_W-1:0] delay_q;
	logic [DLY_W-1:0] delay_eff;
	pdp_cmd_t         cmd;
	pdp_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(delay_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= CFG_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			delay_q <= pwdata[CFG_W-1:0];
		end
	end

	// zero acts as one, anything past MAX_DELAY is clamped to MAX_DELAY
	always_comb begin
		if (delay_q == '0)
			delay_eff = DLY_W'(1);
		else if (int'(delay_q) > MAX_DELAY)
			delay_eff = DLY_W'(MAX_DELAY);
		else
			delay_eff = DLY_W'(delay_q);
	end

	pdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.delay        (delay_eff),
		.opcode       (opcode),
		.restart      (restart),
		.sample       (sample),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.prediction   (prediction),
		.pred_valid   (pred_valid),
		.sq_error     (sq_error),
		.err_valid    (err_valid),
		.error_sum    (error_sum),
		.scored_count (scored_count),
		.saturated    (saturated)
	);

endmodule
